// File: hdl/bfha_pkg.sv
// ----------------------------------------------------------------------------
// bfha_pkg
// Shared constants for the best-fit heap allocator.
// ----------------------------------------------------------------------------
package bfha_pkg;

  localparam int unsigned MaxChunksDefault    = 64;
  localparam int unsigned HeapAddrBitsDefault = 24;
  localparam int unsigned HeaderBytesDefault  = 32;
  localparam int unsigned GranuleDefault      = 16;
  localparam int unsigned InitialPagesDefault = 256;
  localparam int unsigned ExtendPagesDefault  = 16;

  localparam int unsigned CmdW    = 2;
  localparam int unsigned SizeW   = 24;
  localparam int unsigned AlignW  = 17;
  localparam int unsigned AddrW   = 24;
  localparam int unsigned StatusW = 3;
  localparam int unsigned PageLgW = 5;
  localparam logic [PageLgW-1:0] PageLgReset = 5'd12;

  localparam logic [CmdW-1:0] CmdAlloc  = 2'd0;
  localparam logic [CmdW-1:0] CmdFree   = 2'd1;
  localparam logic [CmdW-1:0] CmdResize = 2'd2;

  localparam logic [StatusW-1:0] StOk       = 3'd0;
  localparam logic [StatusW-1:0] StNoMem    = 3'd1;
  localparam logic [StatusW-1:0] StBadAlign = 3'd2;
  localparam logic [StatusW-1:0] StBigAlign = 3'd3;
  localparam logic [StatusW-1:0] StBadAddr  = 3'd4;
  localparam logic [StatusW-1:0] StMove     = 3'd5;

endpackage

// File: hdl/best_fit_heap_allocator_core.sv
// Alloc: a best-fit scan of the chunk memory, then, on a split, the entries after the
// granted chunk are moved up by one. Free and resize: a search for the chunk, then
// entries are moved when chunks merge or split. One word at a time, the next accepted
// in the strobe cycle. Results cannot be stalled.
// Reset: async, active low; heap empty, page_log2 = 12.
// ----------------------------------------------------------------------------
// best_fit_heap_allocator_core
// Chunk table held in one synchronous memory, walked by a sequencer.
// ----------------------------------------------------------------------------
module best_fit_heap_allocator_core #(
  parameter int unsigned MAX_CHUNKS       = bfha_pkg::MaxChunksDefault,
  parameter int unsigned HEAP_ADDR_BITS   = bfha_pkg::HeapAddrBitsDefault,
  parameter int unsigned HEADER_BYTES     = bfha_pkg::HeaderBytesDefault,
  parameter int unsigned GRANULE          = bfha_pkg::GranuleDefault,
  parameter int unsigned INITIAL_PAGES    = bfha_pkg::InitialPagesDefault,
  parameter int unsigned EXTEND_MIN_PAGES = bfha_pkg::ExtendPagesDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bfha_pkg::PageLgW-1:0] cfg_wdata_i,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [bfha_pkg::CmdW-1:0]    cmd_i,
  input  logic [bfha_pkg::SizeW-1:0]   size_i,
  input  logic [bfha_pkg::AlignW-1:0]  alignment_i,
  input  logic [bfha_pkg::AddrW-1:0]   address_i,
  output logic                         strobe_o,
  output logic [bfha_pkg::StatusW-1:0] status_o,
  output logic [bfha_pkg::AddrW-1:0]   address_out_o,
  output logic [bfha_pkg::SizeW-1:0]   usable_size_o
);
  import bfha_pkg::*;

  localparam int unsigned IdxW = $clog2(MAX_CHUNKS);
  localparam int unsigned CntW = $clog2(MAX_CHUNKS + 1);
  localparam int unsigned W    = HEAP_ADDR_BITS + 2;   // internal arithmetic
  localparam logic [W-1:0] Hdr   = W'(HEADER_BYTES);
  localparam logic [W-1:0] Gran  = W'(GRANULE);
  localparam logic [W-1:0] Limit = W'(1) << HEAP_ADDR_BITS;
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_CHUNKS);

  typedef struct packed {
    logic [HEAP_ADDR_BITS-1:0] start;
    logic [HEAP_ADDR_BITS-1:0] size;
    logic                      used;
  } ent_t;

  typedef enum logic [4:0] {
    S_IDLE, S_LAYOUT, S_SCAN_RD, S_SCAN, S_PICK, S_EXT, S_SPLIT_CHK, S_SHR_RD, S_SHR_WR,
    S_SPL_WR, S_FIND, S_FREE_PREV, S_FREE_NEXT, S_MERGE, S_SHL_RD, S_SHL_WR,
    S_RS_CHK, S_RS_NEXT, S_DONE
  } state_e;

  ent_t mem_q [MAX_CHUNKS];
  logic            we;
  logic [IdxW-1:0] waddr, raddr;
  ent_t            wdata, rdata_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  state_e          state_q;
  logic [PageLgW-1:0] pglg_q;
  logic [CntW-1:0] cnt_q;
  logic [W-1:0]    top_q;
  logic            ready_q;
  logic [CmdW-1:0] cmd_q;
  logic            rs_q;          // resize path
  logic            grow_q;        // merge that continues after the shift (prev on free, next on resize)
  logic [W-1:0]    sz_q, align_q, addr_q;
  logic [CntW-1:0] i_q, best_q, j_q, sh_q;
  logic            found_q;
  ent_t            bent_q, pend_q;
  logic [StatusW-1:0] st_q;
  logic [AddrW-1:0]   aout_q;
  logic [SizeW-1:0]   us_q;
  logic               strobe_q;

  logic [4:0] pl;
  logic [W-1:0] pg;
  always_comb begin
    pl = (pglg_q < 5'd8) ? 5'd8 : (pglg_q > 5'd16) ? 5'd16 : pglg_q;
    pg = W'(1) << pl;
  end

  // combinational helpers
  logic [W-1:0] rs, rz, want, ext, tot, align_mask;
  always_comb begin
    rs   = W'(rdata_q.start);
    rz   = W'(rdata_q.size);
    want = (sz_q < (W'(EXTEND_MIN_PAGES) << pl)) ? (W'(EXTEND_MIN_PAGES) << pl) : sz_q;
    ext  = (want + Hdr + pg - W'(1)) & ~(pg - W'(1));
    tot  = W'(INITIAL_PAGES) << pl;
    align_mask = align_q - W'(1);
  end

  assign busy_o        = (state_q != S_IDLE);
  assign strobe_o      = strobe_q;
  assign status_o      = st_q;
  assign address_out_o = aout_q;
  assign usable_size_o = us_q;

  logic [W-1:0] szin;
  logic [AlignW-1:0] al;
  assign szin = (W'(size_i) + Gran - W'(1)) & ~(Gran - W'(1));
  assign al = alignment_i;

  always_comb begin
    we = 1'b0; waddr = '0; wdata = '0; raddr = '0;
    unique case (state_q)
      S_SCAN_RD, S_SCAN, S_FIND: raddr = i_q[IdxW-1:0];
      S_SHR_RD: raddr = j_q[IdxW-1:0] - IdxW'(1);
      S_SHL_RD: raddr = j_q[IdxW-1:0] + IdxW'(1);
      S_FREE_PREV: raddr = best_q[IdxW-1:0] - IdxW'(1);
      S_FREE_NEXT, S_RS_NEXT, S_RS_CHK: raddr = best_q[IdxW-1:0] + IdxW'(1);
      default: raddr = '0;
    endcase
    unique case (state_q)
      S_LAYOUT: begin
        we = !ready_q && (tot <= Limit); waddr = '0;
        wdata = '{start: '0, size: HEAP_ADDR_BITS'(tot - (Hdr << 1)), used: 1'b0};
      end
      S_EXT: begin
        we = 1'b1; waddr = cnt_q[IdxW-1:0]; wdata = bent_q;
      end
      S_SHR_WR: begin
        we = 1'b1; waddr = j_q[IdxW-1:0]; wdata = rdata_q;
      end
      S_SPL_WR: begin
        we = 1'b1; waddr = sh_q[IdxW-1:0]; wdata = pend_q;
      end
      S_SHL_WR: begin
        we = 1'b1; waddr = j_q[IdxW-1:0]; wdata = rdata_q;
      end
      S_MERGE: begin
        we = 1'b1; waddr = best_q[IdxW-1:0]; wdata = bent_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; pglg_q <= PageLgReset; cnt_q <= '0; top_q <= '0;
      ready_q <= 1'b0; strobe_q <= 1'b0; st_q <= StOk; aout_q <= '0; us_q <= '0;
      cmd_q <= '0; rs_q <= 1'b0; grow_q <= 1'b0; sz_q <= '0; align_q <= '0;
      addr_q <= '0; i_q <= '0; best_q <= '0; j_q <= '0; sh_q <= '0; found_q <= 1'b0;
      bent_q <= '0; pend_q <= '0;
    end else begin
      strobe_q <= 1'b0;
      if (cfg_we_i) pglg_q <= cfg_wdata_i;
      unique case (state_q)
        S_IDLE: if (start_i) begin
          cmd_q <= (cmd_i == CmdResize && size_i == '0) ? CmdFree : cmd_i;
          sz_q <= szin; addr_q <= W'(address_i);
          st_q <= StOk; aout_q <= '0; us_q <= '0; rs_q <= 1'b0; grow_q <= 1'b0;
          i_q <= '0; found_q <= 1'b0;
          unique case (cmd_i)
            CmdAlloc: begin
              align_q <= W'(al);
              if (al == '0 || (al & (al - AlignW'(1))) != '0) begin
                st_q <= StBadAlign; state_q <= S_DONE;
              end else if (W'(al) > pg) begin
                st_q <= StBigAlign; state_q <= S_DONE;
              end else state_q <= S_LAYOUT;
            end
            CmdFree: begin
              if (address_i == '0) state_q <= S_DONE;
              else state_q <= S_FIND;
            end
            CmdResize: begin
              align_q <= Gran;
              if (address_i == '0) state_q <= S_LAYOUT;
              else begin
                rs_q <= (size_i != '0); state_q <= S_FIND;
              end
            end
            default: state_q <= S_DONE;
          endcase
        end
        S_LAYOUT: begin
          if (ready_q) state_q <= S_SCAN_RD;
          else if (tot > Limit) begin
            st_q <= StNoMem; state_q <= S_DONE;
          end else begin
            ready_q <= 1'b1; cnt_q <= CntW'(1); top_q <= tot; state_q <= S_SCAN_RD;
          end
        end
        S_SCAN_RD: state_q <= (i_q < cnt_q) ? S_SCAN : S_PICK;
        S_SCAN: begin
          if (!rdata_q.used && rz >= sz_q && ((rs + Hdr) & align_mask) == '0 &&
              (!found_q || rdata_q.size < bent_q.size)) begin
            found_q <= 1'b1; best_q <= i_q; bent_q <= rdata_q;
          end
          i_q <= i_q + CntW'(1);
          state_q <= S_SCAN_RD;
        end
        S_PICK: begin
          if (found_q) begin
            bent_q.used <= 1'b1; state_q <= S_SPLIT_CHK;
          end else if (cnt_q >= MaxCnt || (top_q & align_mask) != '0 ||
                       top_q + ext > Limit) begin
            st_q <= StNoMem; state_q <= S_DONE;
          end else begin
            bent_q <= '{start: HEAP_ADDR_BITS'(top_q - Hdr),
                        size: HEAP_ADDR_BITS'(ext - Hdr), used: 1'b1};
            best_q <= cnt_q; top_q <= top_q + ext; state_q <= S_EXT;
          end
        end
        S_EXT: begin
          cnt_q <= cnt_q + CntW'(1); state_q <= S_SPLIT_CHK;
        end
        S_SPLIT_CHK: begin
          // bent_q is the chunk to grant; write back via split or merge path
          if (W'(bent_q.size) >= sz_q + Hdr + Gran && cnt_q < MaxCnt) begin
            pend_q <= '{start: HEAP_ADDR_BITS'(W'(bent_q.start) + Hdr + sz_q),
                        size: HEAP_ADDR_BITS'(W'(bent_q.size) - sz_q - Hdr), used: 1'b0};
            bent_q.size <= HEAP_ADDR_BITS'(sz_q);
            sh_q <= best_q + CntW'(1); j_q <= cnt_q;
            state_q <= (cnt_q > best_q + CntW'(1)) ? S_SHR_RD : S_SPL_WR;
          end else begin
            sh_q <= '1; state_q <= S_MERGE;
          end
        end
        S_SHR_RD: state_q <= S_SHR_WR;
        S_SHR_WR: begin
          j_q <= j_q - CntW'(1);
          state_q <= (j_q - CntW'(1) > sh_q) ? S_SHR_RD : S_SPL_WR;
        end
        S_SPL_WR: begin
          cnt_q <= cnt_q + CntW'(1); sh_q <= '1; state_q <= S_MERGE;
        end
        S_FIND: begin
          if (i_q < cnt_q) begin
            // read issued on previous visit; first visit primes the pipe
            if (found_q && rdata_q.used &&
                W'(rdata_q.start) + Hdr == addr_q) begin
              best_q <= i_q - CntW'(1); bent_q <= rdata_q; state_q <= S_FREE_PREV;
            end else begin
              found_q <= 1'b1; i_q <= i_q + CntW'(1);
            end
          end else if (found_q && rdata_q.used && W'(rdata_q.start) + Hdr == addr_q) begin
            best_q <= i_q - CntW'(1); bent_q <= rdata_q; state_q <= S_FREE_PREV;
          end else begin
            st_q <= StBadAddr; state_q <= S_DONE;
          end
        end
        S_FREE_PREV: begin
          if (rs_q) begin
            state_q <= S_RS_NEXT;
          end else begin
            bent_q.used <= 1'b0; grow_q <= 1'b0; state_q <= S_FREE_NEXT;
          end
        end
        S_FREE_NEXT: begin
          // rdata_q = entry best-1 (read issued in FREE_PREV)
          if (best_q != '0 && !rdata_q.used) begin
            bent_q <= '{start: rdata_q.start,
                        size: HEAP_ADDR_BITS'(rz + W'(bent_q.size) + Hdr), used: 1'b0};
            best_q <= best_q - CntW'(1);
            j_q <= best_q; sh_q <= best_q;
            state_q <= S_SHL_RD; grow_q <= 1'b1;
          end else begin
            sh_q <= '1; j_q <= best_q + CntW'(1); state_q <= S_RS_NEXT;
          end
        end
        S_RS_NEXT: begin
          // issue the read of best+1; its data is valid in RS_CHK
          state_q <= S_RS_CHK;
        end
        S_RS_CHK: begin
          if (!rs_q) begin
            if (best_q + CntW'(1) < cnt_q && !rdata_q.used) begin
              bent_q.size <= HEAP_ADDR_BITS'(W'(bent_q.size) + rz + Hdr);
              j_q <= best_q + CntW'(1); state_q <= S_SHL_RD; grow_q <= 1'b0;
            end else state_q <= S_MERGE;
          end else if (sz_q <= W'(bent_q.size)) begin
            aout_q <= AddrW'(addr_q); state_q <= S_SPLIT_CHK;
          end else if (best_q + CntW'(1) < cnt_q && !rdata_q.used &&
                       sz_q - W'(bent_q.size) <= rz + Hdr) begin
            bent_q.size <= HEAP_ADDR_BITS'(W'(bent_q.size) + rz + Hdr);
            j_q <= best_q + CntW'(1); rs_q <= 1'b0; grow_q <= 1'b1;
            cmd_q <= CmdResize; state_q <= S_SHL_RD;
          end else begin
            st_q <= StMove; aout_q <= AddrW'(addr_q); us_q <= bent_q.size;
            state_q <= S_DONE;
          end
        end
        S_SHL_RD: begin
          if (j_q + CntW'(1) < cnt_q) state_q <= S_SHL_WR;
          else begin
            cnt_q <= cnt_q - CntW'(1);
            if (grow_q && cmd_q == CmdResize) state_q <= S_SPLIT_CHK;
            else if (grow_q) begin
              grow_q <= 1'b0; state_q <= S_RS_NEXT;
            end else state_q <= S_MERGE;
          end
        end
        S_SHL_WR: begin
          j_q <= j_q + CntW'(1); state_q <= S_SHL_RD;
        end
        S_MERGE: begin
          if (bent_q.used) begin
            aout_q <= AddrW'(W'(bent_q.start) + Hdr); us_q <= bent_q.size;
          end
          state_q <= S_DONE;
        end
        S_DONE: begin
          strobe_q <= 1'b1; state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// File: bench/bfha_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bfha_checker
// Watches the command and result ports of the best-fit heap allocator, keeps
// its own chunk table, predicts each result word and compares it in order.
// ----------------------------------------------------------------------------
module bfha_checker
  import bfha_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [PageLgW-1:0] cfg_wdata_i,
  input  logic               start_i,
  input  logic               busy_o,
  input  logic [CmdW-1:0]    cmd_i,
  input  logic [SizeW-1:0]   size_i,
  input  logic [AlignW-1:0]  alignment_i,
  input  logic [AddrW-1:0]   address_i,
  input  logic               strobe_o,
  input  logic [StatusW-1:0] status_o,
  input  logic [AddrW-1:0]   address_out_o,
  input  logic [SizeW-1:0]   usable_size_o,
  output int                 mismatches_o,
  output int                 pending_o
);

  localparam int Chunks = MaxChunksDefault;
  localparam longint unsigned Hdr = HeaderBytesDefault;
  localparam longint unsigned Gran = GranuleDefault;
  localparam longint unsigned InitPages = InitialPagesDefault;
  localparam longint unsigned ExtPages = ExtendPagesDefault;
  localparam longint unsigned HeapLimit = 64'd1 << HeapAddrBitsDefault;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [AddrW-1:0]   addr;
    logic [SizeW-1:0]   usable;
  } grant_t;

  grant_t grant_q[$];

  longint unsigned chunk_base [Chunks];
  longint unsigned chunk_len  [Chunks];
  bit              chunk_taken[Chunks];
  int              chunk_cnt;
  longint unsigned top_addr;
  bit              laid_out;
  logic [PageLgW-1:0] pg_lg;

  function automatic longint unsigned page_size();
    int lg;
    lg = pg_lg;
    if (lg < 8) lg = 8;
    if (lg > 16) lg = 16;
    return 64'd1 << lg;
  endfunction

  function automatic bit insert_chunk(int i, longint unsigned b, longint unsigned l, bit t);
    if (chunk_cnt >= Chunks || i > chunk_cnt) return 0;
    for (int k = chunk_cnt; k > i; k--) begin
      chunk_base[k]  = chunk_base[k-1];
      chunk_len[k]   = chunk_len[k-1];
      chunk_taken[k] = chunk_taken[k-1];
    end
    chunk_base[i]  = b;
    chunk_len[i]   = l;
    chunk_taken[i] = t;
    chunk_cnt++;
    return 1;
  endfunction

  function automatic void drop_chunk(int i);
    for (int k = i; k < chunk_cnt - 1; k++) begin
      chunk_base[k]  = chunk_base[k+1];
      chunk_len[k]   = chunk_len[k+1];
      chunk_taken[k] = chunk_taken[k+1];
    end
    chunk_cnt--;
  endfunction

  function automatic int find_granted(longint unsigned a);
    for (int k = 0; k < chunk_cnt; k++)
      if (chunk_taken[k] && chunk_base[k] + Hdr == a) return k;
    return -1;
  endfunction

  function automatic void split_chunk(int i, longint unsigned sz);
    if (chunk_len[i] >= sz + Hdr + Gran)
      if (insert_chunk(i + 1, chunk_base[i] + Hdr + sz, chunk_len[i] - sz - Hdr, 1'b0))
        chunk_len[i] = sz;
  endfunction

  function automatic logic [StatusW-1:0] alloc_chunk(longint unsigned sz,
      longint unsigned align, output longint unsigned aout, output longint unsigned usable);
    int best;
    longint unsigned total, pg, want, ext;
    best = -1;
    aout = 0;
    usable = 0;
    if (!laid_out) begin
      total = page_size() * InitPages;
      if (total > HeapLimit) return StNoMem;
      chunk_cnt      = 1;
      chunk_base[0]  = 0;
      chunk_len[0]   = total - 2 * Hdr;
      chunk_taken[0] = 1'b0;
      top_addr       = total;
      laid_out       = 1'b1;
    end
    for (int k = 0; k < chunk_cnt; k++)
      if (!chunk_taken[k] && chunk_len[k] >= sz && (chunk_base[k] + Hdr) % align == 0 &&
          (best < 0 || chunk_len[k] < chunk_len[best]))
        best = k;
    if (best < 0) begin
      pg = page_size();
      want = sz;
      if (want < ExtPages * pg) want = ExtPages * pg;
      ext = ((want + Hdr + pg - 1) / pg) * pg;
      if (chunk_cnt >= Chunks) return StNoMem;
      if (top_addr % align != 0) return StNoMem;
      if (top_addr + ext > HeapLimit) return StNoMem;
      void'(insert_chunk(chunk_cnt, top_addr - Hdr, ext - Hdr, 1'b0));
      top_addr += ext;
      best = chunk_cnt - 1;
    end
    chunk_taken[best] = 1'b1;
    split_chunk(best, sz);
    aout = chunk_base[best] + Hdr;
    usable = chunk_len[best];
    return StOk;
  endfunction

  function automatic logic [StatusW-1:0] free_chunk(longint unsigned a);
    int i;
    if (a == 0) return StOk;
    i = find_granted(a);
    if (i < 0) return StBadAddr;
    chunk_taken[i] = 1'b0;
    if (i > 0 && !chunk_taken[i-1]) begin
      chunk_len[i-1] += chunk_len[i] + Hdr;
      drop_chunk(i);
      i--;
    end
    if (i + 1 < chunk_cnt && !chunk_taken[i+1]) begin
      chunk_len[i] += chunk_len[i+1] + Hdr;
      drop_chunk(i + 1);
    end
    return StOk;
  endfunction

  function automatic grant_t predict_word(logic [CmdW-1:0] cmd, longint unsigned size,
      longint unsigned align, longint unsigned a);
    grant_t g;
    longint unsigned sz, aout, usable, cur;
    int i;
    aout = 0;
    usable = 0;
    g.status = StOk;
    sz = ((size + Gran - 1) / Gran) * Gran;
    case (cmd)
      CmdAlloc: begin
        if (align == 0 || (align & (align - 1)) != 0) g.status = StBadAlign;
        else if (align > page_size()) g.status = StBigAlign;
        else g.status = alloc_chunk(sz, align, aout, usable);
      end
      CmdFree: g.status = free_chunk(a);
      CmdResize: begin
        if (a == 0) g.status = alloc_chunk(sz, Gran, aout, usable);
        else if (size == 0) g.status = free_chunk(a);
        else begin
          i = find_granted(a);
          if (i < 0) g.status = StBadAddr;
          else begin
            cur = chunk_len[i];
            if (sz <= cur) begin
              split_chunk(i, sz);
              aout = a;
              usable = chunk_len[i];
            end else if (i + 1 < chunk_cnt && !chunk_taken[i+1] &&
                         sz - cur <= chunk_len[i+1] + Hdr) begin
              chunk_len[i] += chunk_len[i+1] + Hdr;
              drop_chunk(i + 1);
              split_chunk(i, sz);
              aout = a;
              usable = chunk_len[i];
            end else begin
              g.status = StMove;
              aout = a;
              usable = cur;
            end
          end
        end
      end
      default: ;
    endcase
    g.addr = aout[AddrW-1:0];
    g.usable = usable[SizeW-1:0];
    return g;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    grant_t want;
    if (!rst_ni) begin
      grant_q.delete();
      chunk_cnt = 0;
      top_addr = 0;
      laid_out = 1'b0;
      pg_lg = PageLgReset;
      mismatches_o = 0;
      pending_o = 0;
    end else begin
      if (strobe_o) begin
        if (grant_q.size() == 0) begin
          if (mismatches_o < 10)
            $display("%0t: result word with nothing pending: st=%0d addr=%h size=%h",
                     $realtime, status_o, address_out_o, usable_size_o);
          mismatches_o++;
        end else begin
          want = grant_q.pop_front();
          if (status_o !== want.status || address_out_o !== want.addr ||
              usable_size_o !== want.usable) begin
            if (mismatches_o < 10)
              $display("%0t: mismatch exp st=%0d addr=%h size=%h got st=%0d addr=%h size=%h",
                       $realtime, want.status, want.addr, want.usable,
                       status_o, address_out_o, usable_size_o);
            mismatches_o++;
          end
        end
      end
      if (cfg_we_i) pg_lg = cfg_wdata_i;
      if (start_i && !busy_o)
        grant_q.push_back(predict_word(cmd_i, size_i, alignment_i, address_i));
      pending_o = grant_q.size();
    end
  end

endmodule

// File: bench/tb_best_fit_heap_allocator_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_best_fit_heap_allocator_core
// Drives directed and random alloc/free/resize words through the allocator
// under several page sizes; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_best_fit_heap_allocator_core;
  import bfha_pkg::*;

  localparam logic [CmdW-1:0] CmdNone = 2'd3;
  localparam int RandItems = 1800;
  localparam longint CycleLimit = 3_000_000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [PageLgW-1:0] cfg_wdata_i = '0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic [CmdW-1:0]    cmd_i = CmdAlloc;
  logic [SizeW-1:0]   size_i = '0;
  logic [AlignW-1:0]  alignment_i = '0;
  logic [AddrW-1:0]   address_i = '0;
  logic               strobe_o;
  logic [StatusW-1:0] status_o;
  logic [AddrW-1:0]   address_out_o;
  logic [SizeW-1:0]   usable_size_o;
  int                 mismatches, pending;
  int                 idle_pct = 0;
  longint             cycles = 0;
  logic [AddrW-1:0]   live_q[$];

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  best_fit_heap_allocator_core dut (.*);

  bfha_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .start_i, .busy_o, .cmd_i, .size_i,
    .alignment_i, .address_i, .strobe_o, .status_o, .address_out_o, .usable_size_o,
    .mismatches_o(mismatches), .pending_o(pending)
  );

  task automatic drop_live(logic [AddrW-1:0] a);
    for (int k = 0; k < live_q.size(); k++)
      if (live_q[k] == a) begin
        live_q.delete(k);
        return;
      end
  endtask

  task automatic issue(logic [CmdW-1:0] c, logic [SizeW-1:0] s, logic [AlignW-1:0] al,
                       logic [AddrW-1:0] a, output logic [AddrW-1:0] got);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) @(negedge clk_i);
    start_i = 1'b1;
    cmd_i = c;
    size_i = s;
    alignment_i = al;
    address_i = a;
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
    start_i = 1'b0;
    do @(posedge clk_i); while (!strobe_o);
    got = address_out_o;
    if (status_o == StOk) begin
      if ((c == CmdAlloc || (c == CmdResize && a == '0)) && address_out_o != '0)
        live_q.push_back(address_out_o);
      if ((c == CmdFree || (c == CmdResize && s == '0)) && a != '0) drop_live(a);
    end
  endtask

  task automatic write_page(logic [PageLgW-1:0] v);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_wdata_i = v;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic random_word();
    int r, sel;
    logic [SizeW-1:0] s;
    logic [AlignW-1:0] al;
    logic [AddrW-1:0] a, got;
    r = $urandom_range(99);
    if (live_q.size() > 40 && r < 40) r = 50;
    sel = $urandom_range(99);
    if (sel < 70) s = SizeW'($urandom_range(0, 2048));
    else if (sel < 90) s = SizeW'($urandom_range(0, 65536));
    else if (sel < 98) s = SizeW'($urandom_range(0, 1 << 20));
    else s = SizeW'($urandom);
    sel = $urandom_range(99);
    if (sel < 85) al = 17'd1 << $urandom_range(4, 12);
    else if (sel < 93) al = 17'd1 << $urandom_range(0, 16);
    else if (sel < 98) al = AlignW'($urandom);
    else al = '0;
    sel = $urandom_range(99);
    if (live_q.size() > 0 && sel < 85) a = live_q[$urandom_range(0, live_q.size() - 1)];
    else if (sel < 90) a = '0;
    else if (sel < 95 && live_q.size() > 0) a = live_q[0] + 24'd16;
    else a = AddrW'($urandom);
    if (r < 40) issue(CmdAlloc, s, al, AddrW'($urandom), got);
    else if (r < 70) issue(CmdFree, SizeW'($urandom), AlignW'($urandom), a, got);
    else if (r < 95) issue(CmdResize, s, AlignW'($urandom), a, got);
    else issue(CmdNone, SizeW'($urandom), AlignW'($urandom), AddrW'($urandom), got);
  endtask

  initial begin
    logic [AddrW-1:0] a, b, got;
    logic [PageLgW-1:0] pages[6];
    pages = '{5'd8, 5'd16, 5'd12, 5'd31, 5'd0, 5'd10};
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    issue(CmdFree, '0, '0, 24'd48, got);
    issue(CmdResize, 24'd16, '0, 24'd48, got);
    issue(CmdAlloc, '0, 17'd16, '0, a);
    issue(CmdAlloc, 24'd64, 17'd0, '0, got);
    issue(CmdAlloc, 24'd64, 17'd3, '0, got);
    issue(CmdAlloc, 24'd64, 17'h1ffff, '0, got);
    issue(CmdAlloc, 24'd64, 17'h10000, '0, got);
    issue(CmdAlloc, 24'hffffff, 17'd16, '0, got);
    issue(CmdAlloc, 24'd100, 17'd4096, '0, got);
    issue(CmdAlloc, 24'd1000, 17'd1, '0, b);
    issue(CmdFree, '0, '0, '0, got);
    issue(CmdNone, 24'hffffff, 17'h1ffff, 24'hffffff, got);
    issue(CmdFree, '0, '0, a, got);
    issue(CmdFree, '0, '0, a, got);
    issue(CmdResize, 24'd200, '0, '0, a);
    issue(CmdResize, '0, '0, a, got);
    issue(CmdAlloc, 24'd48, 17'd16, '0, a);
    issue(CmdAlloc, 24'd480, 17'd16, '0, b);
    issue(CmdFree, '0, '0, b, got);
    issue(CmdResize, 24'd300, '0, a, got);
    issue(CmdResize, 24'd16, '0, a, got);
    issue(CmdResize, 24'd1 << 22, '0, a, got);
    issue(CmdFree, '0, '0, 24'd1, got);

    for (int n = 0; n < RandItems; n++) begin
      if (n % 300 == 0) write_page(pages[n / 300]);
      idle_pct = (n < 600) ? 31 : (n < 1200) ? 82 : 0;
      random_word();
    end

    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
